[rtl/wrl_pkg.sv]
// Shared constants, widths and register codes for the windowed RMS level block.
package wrl_pkg;

  localparam int WINDOW    = 44;
  localparam int SAMPLE_W  = 12;
  localparam int GAIN_W    = 16;
  localparam int LEVEL_W   = 16;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 9;
  localparam int FRAC_W    = 8;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int ALU_W     = REM_W;
  localparam int STEP_W    = $clog2(ROOT_W);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // reciprocal of WINDOW, exact floor division for any SUM_W-bit dividend
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int MAGIC_W   = SUM_W + 1;
  localparam int MUL_W     = SUM_W + MAGIC_W;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC =
    MAGIC_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW));

  localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(1599);
  localparam logic              ENABLE_RESET = 1'b1;

  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

endpackage

[rtl/wrl_if.sv]
// Valid/ready channel interfaces for converter samples and level results.
interface wrl_sample_if;
  logic                          valid;
  logic                          ready;
  logic [wrl_pkg::SAMPLE_W-1:0]  adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface wrl_level_if;
  logic                         valid;
  logic                         ready;
  logic [wrl_pkg::LEVEL_W-1:0]  rms_level;

  modport source (output valid, output rms_level, input ready);
  modport sink (input valid, input rms_level, output ready);
endinterface

[rtl/windowed_rms_level.sv]
// Windowed RMS level: square accumulator, shared multiplier and a root subtractor.
// A sample that does not close the window is taken while ready stays high.
// The closing sample starts a reciprocal divide by WINDOW (quotient, remainder, fraction),
// then a 16-step root, then the gain multiply, which registers the level; ready is low
// from that transaction until the level is registered (including any output stall).
// Synchronous reset clears the sum, count and output valid; gain returns to 1599, enable to 1.
module windowed_rms_level (
  input  logic                        clk,
  input  logic                        rst,
  wrl_sample_if.sink                  samples,
  wrl_level_if.source                 levels,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wrl_pkg::ADDR_W-1:0]  paddr,
  input  logic [wrl_pkg::DATA_W-1:0]  pwdata,
  output logic [wrl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUO,
    S_REM,
    S_FRAC,
    S_SQRT,
    S_MUL
  } state_t;

  state_t                            state;
  logic [wrl_pkg::GAIN_W-1:0]        gain;
  logic                              enable;
  logic [wrl_pkg::SUM_W-1:0]         square_sum;
  logic [wrl_pkg::CNT_W-1:0]         sample_count;
  logic [wrl_pkg::SUM_W-1:0]         work;
  logic [wrl_pkg::SUM_W-1:0]         quo;
  logic [wrl_pkg::REM_W-1:0]         rem;
  logic [wrl_pkg::ROOT_W-1:0]        root;
  logic [wrl_pkg::STEP_W-1:0]        step;
  logic                              out_valid;
  logic [wrl_pkg::LEVEL_W-1:0]       out_level;

  logic                              accept;
  logic                              cfg_write;
  logic [2*wrl_pkg::SAMPLE_W-1:0]    square;
  logic [wrl_pkg::SUM_W-1:0]         sum_next;
  logic [wrl_pkg::CNT_W-1:0]         count_next;
  logic [wrl_pkg::REM_W-1:0]         sqrt_shift;
  logic [wrl_pkg::REM_W-1:0]         sqrt_trial;
  logic [wrl_pkg::ALU_W:0]           alu_diff;
  logic                              alu_ge;
  logic [wrl_pkg::SUM_W-1:0]         mul_a;
  logic [wrl_pkg::MAGIC_W-1:0]       mul_b;
  logic [wrl_pkg::MUL_W-1:0]         mul_p;
  logic                              out_free;

  assign samples.ready   = (state == S_IDLE);
  assign accept          = samples.valid && samples.ready;
  assign levels.valid    = out_valid;
  assign levels.rms_level = out_level;
  assign out_free        = !out_valid || levels.ready;
  assign pready          = 1'b1;
  assign cfg_write       = psel && penable && pwrite && pready;

  assign square     = (2*wrl_pkg::SAMPLE_W)'(samples.adc_sample) *
                      (2*wrl_pkg::SAMPLE_W)'(samples.adc_sample);
  assign sum_next   = square_sum + wrl_pkg::SUM_W'(square);
  assign count_next = sample_count + wrl_pkg::CNT_W'(1);

  assign sqrt_shift = {rem[wrl_pkg::REM_W-3:0], work[wrl_pkg::SUM_W-1 -: 2]};
  assign sqrt_trial = {root, 2'b01};

  // root subtract/compare unit
  assign alu_diff = {1'b0, sqrt_shift} - {1'b0, sqrt_trial};
  assign alu_ge   = !alu_diff[wrl_pkg::ALU_W];

  // shared multiplier: reciprocal divide, then gain scaling
  always_comb begin
    unique case (state)
      S_QUO: begin
        mul_a = work;
        mul_b = wrl_pkg::DIV_MAGIC;
      end
      S_FRAC: begin
        mul_a = work << wrl_pkg::FRAC_W;
        mul_b = wrl_pkg::DIV_MAGIC;
      end
      default: begin
        mul_a = wrl_pkg::SUM_W'(root);
        mul_b = wrl_pkg::MAGIC_W'(gain);
      end
    endcase
  end

  assign mul_p = wrl_pkg::MUL_W'(mul_a) * wrl_pkg::MUL_W'(mul_b);

  always_comb begin
    unique case (paddr[2])
      wrl_pkg::REG_GAIN:   prdata = wrl_pkg::DATA_W'(gain);
      wrl_pkg::REG_ENABLE: prdata = wrl_pkg::DATA_W'(enable);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      gain         <= wrl_pkg::GAIN_RESET;
      enable       <= wrl_pkg::ENABLE_RESET;
      square_sum   <= '0;
      sample_count <= '0;
      out_valid    <= 1'b0;
      step         <= '0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[2])
          wrl_pkg::REG_GAIN:   gain <= pwdata[wrl_pkg::GAIN_W-1:0];
          wrl_pkg::REG_ENABLE: enable <= pwdata[0];
          default: ;
        endcase
      end
      if (state == S_MUL && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && levels.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && enable) begin
            if (count_next == wrl_pkg::CNT_W'(wrl_pkg::WINDOW)) begin
              square_sum   <= '0;
              sample_count <= '0;
              work         <= sum_next;
              state        <= S_QUO;
            end else begin
              square_sum   <= sum_next;
              sample_count <= count_next;
            end
          end
        end
        S_QUO: begin
          quo   <= wrl_pkg::SUM_W'(mul_p >> wrl_pkg::DIV_SHIFT);
          state <= S_REM;
        end
        S_REM: begin
          // remainder of the window sum, below WINDOW
          work  <= work - wrl_pkg::SUM_W'(quo * wrl_pkg::SUM_W'(wrl_pkg::WINDOW));
          state <= S_FRAC;
        end
        S_FRAC: begin
          // mean in Q.8: quotient shifted up plus the divided remainder
          work  <= {quo[wrl_pkg::SUM_W-wrl_pkg::FRAC_W-1:0], wrl_pkg::FRAC_W'(0)} +
                   wrl_pkg::SUM_W'(mul_p >> wrl_pkg::DIV_SHIFT);
          rem   <= '0;
          root  <= '0;
          step  <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          rem  <= alu_ge ? alu_diff[wrl_pkg::REM_W-1:0] : sqrt_shift;
          root <= {root[wrl_pkg::ROOT_W-2:0], alu_ge};
          work <= {work[wrl_pkg::SUM_W-3:0], 2'b00};
          if (step == wrl_pkg::STEP_W'(wrl_pkg::ROOT_W - 1)) begin
            step  <= '0;
            state <= S_MUL;
          end else begin
            step <= step + wrl_pkg::STEP_W'(1);
          end
        end
        S_MUL: begin
          if (out_free) begin
            out_level <= mul_p[wrl_pkg::GAIN_W +: wrl_pkg::LEVEL_W];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT && step == '0) |-> (rem == '0 && root == '0))
    else $error("root pass did not start from a cleared remainder");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count < wrl_pkg::CNT_W'(wrl_pkg::WINDOW))
    else $error("sample count reached the window length");

  a_close_starts_div: assert property (@(posedge clk) disable iff (rst)
    (accept && enable &&
     sample_count == wrl_pkg::CNT_W'(wrl_pkg::WINDOW - 1)) |=> (state == S_QUO))
    else $error("closing sample did not start the divide");

  a_disabled_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !enable) |=> ($stable(square_sum) && $stable(sample_count)))
    else $error("disabled transaction changed the window state");

  a_result_from_mul: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_MUL))
    else $error("level issued outside the multiply step");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for windowed_rms_level: table-driven windows, then random traffic.
module tb;

  localparam int PHASE_ITEMS   = 280;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 2000;

  localparam logic [wrl_pkg::ADDR_W-1:0] ADDR_GAIN   =
    wrl_pkg::ADDR_W'(4 * int'(wrl_pkg::REG_GAIN));
  localparam logic [wrl_pkg::ADDR_W-1:0] ADDR_ENABLE =
    wrl_pkg::ADDR_W'(4 * int'(wrl_pkg::REG_ENABLE));

  typedef enum logic [1:0] {ROW_FILL, ROW_ALTERNATE, ROW_GAIN, ROW_ENABLE} row_kind_t;
  typedef enum logic [1:0] {SHAPE_UNIFORM, SHAPE_QUIET, SHAPE_LOUD, SHAPE_STEADY} shape_t;

  typedef struct {
    row_kind_t     kind;
    logic [31:0]   value;
    int            reps;
    bit            typed;
    logic [15:0]   level;
  } plan_row_t;

  // typed levels hold only when reps closes a window of constant samples
  plan_row_t plan [16] = '{
    '{ROW_FILL,      32'd0,          wrl_pkg::WINDOW,      1'b1, 16'd0},
    '{ROW_FILL,      32'd4095,       wrl_pkg::WINDOW,      1'b1, 16'd1598},
    '{ROW_GAIN,      32'hFFFF_FFFF,  0,                    1'b0, 16'd0},
    '{ROW_FILL,      32'd4095,       wrl_pkg::WINDOW,      1'b1, 16'd65519},
    '{ROW_FILL,      32'd1,          wrl_pkg::WINDOW,      1'b1, 16'd15},
    '{ROW_ALTERNATE, 32'd0,          wrl_pkg::WINDOW,      1'b0, 16'd0},
    '{ROW_GAIN,      32'd0,          0,                    1'b0, 16'd0},
    '{ROW_FILL,      32'd4095,       wrl_pkg::WINDOW,      1'b1, 16'd0},
    '{ROW_GAIN,      32'h0001_8000,  0,                    1'b0, 16'd0},
    '{ROW_FILL,      32'd2048,       20,                   1'b0, 16'd0},
    '{ROW_ENABLE,    32'hFFFF_FFFE,  0,                    1'b0, 16'd0},
    '{ROW_FILL,      32'd4095,       10,                   1'b0, 16'd0},
    '{ROW_ENABLE,    32'h0000_0003,  0,                    1'b0, 16'd0},
    '{ROW_FILL,      32'd2048,       wrl_pkg::WINDOW - 20, 1'b1, 16'd16384},
    '{ROW_GAIN,      32'd1599,       0,                    1'b0, 16'd0},
    '{ROW_ALTERNATE, 32'd0,          wrl_pkg::WINDOW,      1'b0, 16'd0}
  };

  int tx_pct_by_phase [4] = '{0, 87, 0, 35};
  int rx_pct_by_phase [4] = '{0, 0, 87, 35};

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [wrl_pkg::ADDR_W-1:0]    paddr;
  logic [wrl_pkg::DATA_W-1:0]    pwdata;
  logic [wrl_pkg::DATA_W-1:0]    prdata;
  logic                          pready;

  wrl_sample_if sample_bus ();
  wrl_level_if  level_bus ();

  windowed_rms_level dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .levels  (level_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [wrl_pkg::GAIN_W-1:0]   gain_reg;
  logic                         enable_reg;
  logic [wrl_pkg::SUM_W-1:0]    acc_sq_sum;
  int                           acc_count;
  logic [wrl_pkg::LEVEL_W-1:0]  pending_levels [$];

  int error_count;
  int samples_taken;
  int samples_dropped;
  int levels_seen;
  int reg_writes;
  int tx_idle_pct;
  int rx_stall_pct;
  int stall_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("MISMATCH @%0t %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic logic [23:0] floor_root(input logic [63:0] v);
    logic [23:0] r;
    logic [23:0] cand;
    r = '0;
    for (int b = 23; b >= 0; b--) begin
      cand = r | (24'd1 << b);
      if (64'(cand) * 64'(cand) <= v) r = cand;
    end
    return r;
  endfunction

  function automatic logic [wrl_pkg::LEVEL_W-1:0] rms_level_of(
      input logic [wrl_pkg::SUM_W-1:0] sum, input logic [wrl_pkg::GAIN_W-1:0] g);
    logic [63:0] mean_q8;
    logic [63:0] scaled;
    mean_q8 = (64'(sum) << wrl_pkg::FRAC_W) / 64'(wrl_pkg::WINDOW);
    scaled  = (64'(floor_root(mean_q8)) * 64'(g)) >> 16;
    return scaled[wrl_pkg::LEVEL_W-1:0];
  endfunction

  function automatic logic [wrl_pkg::SAMPLE_W-1:0] pick_sample(
      input shape_t shape, input logic [wrl_pkg::SAMPLE_W-1:0] steady);
    case (shape)
      SHAPE_UNIFORM: return wrl_pkg::SAMPLE_W'($urandom_range(4095));
      SHAPE_QUIET:   return wrl_pkg::SAMPLE_W'($urandom_range(15));
      SHAPE_LOUD:    return wrl_pkg::SAMPLE_W'(4095 - $urandom_range(15));
      default:       return steady;
    endcase
  endfunction

  // one transaction on the sample channel, then update the window state while enabled
  task automatic drive_sample(input logic [wrl_pkg::SAMPLE_W-1:0] v, input bit typed,
                              input logic [wrl_pkg::LEVEL_W-1:0] typed_level);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid      <= 1'b1;
    sample_bus.adc_sample <= v;
    do @(posedge clk); while (sample_bus.ready !== 1'b1);
    if (!enable_reg) begin
      samples_dropped++;
      return;
    end
    samples_taken++;
    acc_sq_sum += wrl_pkg::SUM_W'(v) * wrl_pkg::SUM_W'(v);
    acc_count++;
    if (acc_count == wrl_pkg::WINDOW) begin
      pending_levels.push_back(typed ? typed_level : rms_level_of(acc_sq_sum, gain_reg));
      acc_sq_sum = '0;
      acc_count  = 0;
    end
  endtask

  task automatic wait_idle();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_check(input logic [wrl_pkg::ADDR_W-1:0] addr, input logic [31:0] want,
                            input string what);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic write_reg(input logic [wrl_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    case (addr)
      ADDR_GAIN:   gain_reg   = data[wrl_pkg::GAIN_W-1:0];
      ADDR_ENABLE: enable_reg = data[0];
      default: ;
    endcase
    @(posedge clk);
    if (addr == ADDR_GAIN) read_check(ADDR_GAIN, 32'(gain_reg), "gain readback");
    else read_check(ADDR_ENABLE, 32'(enable_reg), "enable readback");
  endtask

  always @(posedge clk) begin
    level_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && level_bus.valid === 1'b1 && level_bus.ready === 1'b1) begin
      levels_seen++;
      if (pending_levels.size() == 0)
        report_mismatch("rms_level with nothing pending", level_bus.rms_level, 0);
      else if (level_bus.rms_level !== pending_levels[0])
        report_mismatch("rms_level", level_bus.rms_level, pending_levels.pop_front());
      else
        void'(pending_levels.pop_front());
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (rst || (sample_bus.valid === 1'b1 && sample_bus.ready === 1'b1) ||
        (level_bus.valid === 1'b1 && level_bus.ready === 1'b1) ||
        (psel === 1'b1 && penable === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int                            start_count;
    int                            r;
    int                            len;
    shape_t                        shape;
    logic [wrl_pkg::SAMPLE_W-1:0]  steady;
    logic [wrl_pkg::GAIN_W-1:0]    g;

    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    sample_bus.valid      = 1'b0;
    sample_bus.adc_sample = '0;
    gain_reg              = wrl_pkg::GAIN_RESET;
    enable_reg            = wrl_pkg::ENABLE_RESET;
    acc_sq_sum            = '0;
    acc_count             = 0;
    error_count           = 0;
    samples_taken         = 0;
    samples_dropped       = 0;
    levels_seen           = 0;
    reg_writes            = 0;
    tx_idle_pct           = 0;
    rx_stall_pct          = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_check(ADDR_GAIN, 32'd1599, "gain after reset");
    read_check(ADDR_ENABLE, 32'd1, "enable after reset");

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_GAIN: begin
          wait_idle();
          write_reg(ADDR_GAIN, plan[i].value);
        end
        ROW_ENABLE: begin
          wait_idle();
          write_reg(ADDR_ENABLE, plan[i].value);
        end
        default: begin
          for (int k = 0; k < plan[i].reps; k++)
            drive_sample((plan[i].kind == ROW_ALTERNATE) ? ((k % 2) ? 12'h555 : 12'hAAA)
                                                         : plan[i].value[wrl_pkg::SAMPLE_W-1:0],
                         plan[i].typed, plan[i].level);
        end
      endcase
    end

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_pct_by_phase[p];
      rx_stall_pct = rx_pct_by_phase[p];
      start_count  = samples_taken;
      while (samples_taken - start_count < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 10) begin
          case ($urandom_range(3))
            0:       g = '0;
            1:       g = '1;
            2:       g = wrl_pkg::GAIN_RESET;
            default: g = wrl_pkg::GAIN_W'($urandom);
          endcase
          wait_idle();
          write_reg(ADDR_GAIN, {16'($urandom), g});
        end else if (r < 16) begin
          // disabled stretch, which may fall at the start of a window or in its middle
          wait_idle();
          write_reg(ADDR_ENABLE, {31'($urandom), 1'b0});
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++)
            drive_sample(wrl_pkg::SAMPLE_W'($urandom_range(4095)), 1'b0, '0);
          wait_idle();
          write_reg(ADDR_ENABLE, {31'($urandom), 1'b1});
        end else begin
          len    = (r < 85) ? wrl_pkg::WINDOW - acc_count : $urandom_range(1, 60);
          shape  = shape_t'($urandom_range(3));
          steady = wrl_pkg::SAMPLE_W'($urandom_range(4095));
          for (int k = 0; k < len; k++)
            drive_sample(pick_sample(shape, steady), 1'b0, '0);
        end
      end
    end

    wait_idle();
    $display("run: %0d samples windowed, %0d dropped while disabled, %0d levels checked",
             samples_taken, samples_dropped, levels_seen);
    $display("run: %0d register writes, four flow-control phases, %0d mismatches",
             reg_writes, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
